FILE: hdl/sspq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspq_pkg
// Shared types and constants for the stable sorted priority queue.
// ----------------------------------------------------------------------------
package sspq_pkg;

  localparam int DefaultDepth = 16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_REM_EMPTY = 2'd1;
  localparam logic [1:0] ST_INS_FULL  = 2'd2;

  localparam logic signed [31:0] EMPTY_FRONT = 32'sh7FFF_FFFF;

  // Command broadcast to every cell
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } ctl_t;

  // Entry handed between neighboring cells
  typedef struct packed {
    logic               keep;
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } link_t;

endpackage
`default_nettype wire

FILE: hdl/sspq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspq_cell
// One slot of the sorted chain: holds, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module sspq_cell (
  input  wire                  clk,
  input  wire sspq_pkg::ctl_t  ctl,
  input  wire                  occ,
  input  wire sspq_pkg::link_t prev,
  input  wire sspq_pkg::link_t next,
  output sspq_pkg::link_t      self
);

  logic signed [31:0] value_r, value_nxt;
  logic signed [31:0] prio_r, prio_nxt;

  // entry stays in place on insert when it sorts at or before the new one
  assign self.keep  = occ && (prio_r <= ctl.prio);
  assign self.value = value_r;
  assign self.prio  = prio_r;

  always_comb begin
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (ctl.ins && !self.keep) begin
      if (prev.keep) begin
        value_nxt = ctl.value;
        prio_nxt  = ctl.prio;
      end else begin
        value_nxt = prev.value;
        prio_nxt  = prev.prio;
      end
    end else if (ctl.rem) begin
      value_nxt = next.value;
      prio_nxt  = next.prio;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

endmodule
`default_nettype wire

FILE: hdl/stable_sorted_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Shift-register sorted queue, smallest priority first, FIFO among equals.
// ----------------------------------------------------------------------------
// The result is registered: out_valid rises in the cycle after the request is accepted.
// Throughput: 1 request per cycle unless stalled; every cell compares and shifts in parallel.
// A result not yet taken holds off the next request.
// Reset: synchronous rst_n clears the count and the output valid; slots
// keep stale data until written.
module stable_sorted_priority_queue #(
  parameter int Depth = sspq_pkg::DefaultDepth,
  parameter int CntW  = $clog2(Depth + 1)
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire                      in_operation,
  input  wire  signed [31:0]       in_item_value,
  input  wire  signed [31:0]       in_item_priority,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic signed [31:0]       out_front_value,
  output logic                     out_is_empty,
  output logic                     out_is_full,
  output logic [CntW-1:0]          out_entry_count,
  output logic [1:0]               out_status
);

  logic [CntW-1:0]  count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             fire, full, empty;
  sspq_pkg::ctl_t   ctl;
  sspq_pkg::link_t  cells [Depth];
  logic [Depth-1:0] occ;

  assign in_stall = out_valid_r && out_stall;
  assign fire     = in_valid && !in_stall;
  assign full     = (count_r == CntW'(Depth));
  assign empty    = (count_r == '0);

  assign ctl.ins   = fire && (in_operation == sspq_pkg::OP_INSERT) && !full;
  assign ctl.rem   = fire && (in_operation == sspq_pkg::OP_REMOVE) && !empty;
  assign ctl.value = in_item_value;
  assign ctl.prio  = in_item_priority;

  genvar gi;
  generate
    for (gi = 0; gi < Depth; gi++) begin : g_cell
      sspq_pkg::link_t prev_l, next_l;

      assign occ[gi] = (CntW'(gi) < count_r);

      if (gi == 0) begin : g_head
        assign prev_l = '{keep: 1'b1, value: '0, prio: '0};
      end else begin : g_mid
        assign prev_l = cells[gi-1];
      end
      if (gi == Depth - 1) begin : g_tail
        assign next_l = '{keep: 1'b0, value: '0, prio: '0};
      end else begin : g_body
        assign next_l = cells[gi+1];
      end

      sspq_cell u_cell (
        .clk  (clk),
        .ctl  (ctl),
        .occ  (occ[gi]),
        .prev (prev_l),
        .next (next_l),
        .self (cells[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt  = count_r;
    status_nxt = status_r;
    if (ctl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.rem) begin
      count_nxt = count_r - 1'b1;
    end
    if (fire) begin
      priority if (in_operation == sspq_pkg::OP_INSERT && full) begin
        status_nxt = sspq_pkg::ST_INS_FULL;
      end else if (in_operation == sspq_pkg::OP_REMOVE && empty) begin
        status_nxt = sspq_pkg::ST_REM_EMPTY;
      end else begin
        status_nxt = sspq_pkg::ST_OK;
      end
    end
    out_valid_nxt = fire ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_front_value = empty ? sspq_pkg::EMPTY_FRONT : cells[0].value;
  assign out_is_empty    = empty;
  assign out_is_full     = full;
  assign out_entry_count = count_r;
  assign out_status      = status_r;

endmodule
`default_nettype wire

FILE: hdl/sspq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspq_checker
// Port-level checks on the result channel of the sorted queue.
// ----------------------------------------------------------------------------
module sspq_checker #(
  parameter int Depth = sspq_pkg::DefaultDepth,
  parameter int CntW  = $clog2(Depth + 1)
) (
  input wire                clk,
  input wire                rst_n,
  input wire                out_valid,
  input wire                out_stall,
  input wire signed [31:0]  out_front_value,
  input wire                out_is_empty,
  input wire                out_is_full,
  input wire [CntW-1:0]     out_entry_count,
  input wire [1:0]          out_status
);

  a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |->
      out_entry_count == '0 && out_front_value == sspq_pkg::EMPTY_FRONT)
    else $error("empty result with nonzero count or front");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_is_full == (out_entry_count == CntW'(Depth)))
    else $error("full flag disagrees with count");

  a_rem_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == sspq_pkg::ST_REM_EMPTY |-> out_is_empty)
    else $error("remove-from-empty reported on nonempty queue");

  a_ins_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == sspq_pkg::ST_INS_FULL |-> out_is_full)
    else $error("dropped insert reported on non-full queue");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_front_value)
      && $stable(out_entry_count) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind stable_sorted_priority_queue sspq_checker #(
  .Depth (Depth),
  .CntW  (CntW)
) u_sspq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_front_value (out_front_value),
  .out_is_empty    (out_is_empty),
  .out_is_full     (out_is_full),
  .out_entry_count (out_entry_count),
  .out_status      (out_status)
);
`default_nettype wire
